// ===== src/dhlfr_pkg.sv =====
// Package for the dual-header length-prefixed frame receiver.
// Frame constants, store geometry and the structs passed between front, queue and back.
// No dependencies.
`default_nettype none

package dhlfr_pkg;

  localparam int unsigned LENGTH_LIMIT = 50;

  localparam logic [7:0] HEADER_FIRST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT    = 8'hF1;

  // One bank holds one frame; two banks let a drain overlap the next frame.
  localparam int unsigned POS_W   = 6;
  localparam int unsigned BANK_SZ = 1 << POS_W;
  localparam int unsigned TOTAL_W = POS_W + 1;
  localparam int unsigned ADDR_W  = POS_W + 1;
  localparam int unsigned STORE_DEPTH = 2 * BANK_SZ;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic               bank;
    logic [TOTAL_W-1:0] total;
  } frame_desc_t;

endpackage

`default_nettype wire

// ===== src/dhlfr_front.sv =====
// Front parser: checks header, function and length bytes, writes frame bytes
// into the current store bank and posts a frame descriptor on the trailer.
// Depends on dhlfr_pkg.
`default_nettype none

module dhlfr_front
  import dhlfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  output store_wr_t        wr,
  output logic             push,
  output frame_desc_t      push_desc
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_FUNC    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_TRAILER = 3'd5;

  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] remaining, remaining_next;
  logic [POS_W-1:0] count, count_next;
  logic             bank, bank_next;

  logic [POS_W-1:0]   tail_pos;
  logic [TOTAL_W-1:0] raw_total;

  assign tail_pos  = POS_W'(4) + count;
  assign raw_total = {1'b0, count} + TOTAL_W'(5);

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    count_next     = count;
    bank_next      = bank;
    wr.we          = 1'b0;
    wr.addr        = {bank, tail_pos};
    wr.data        = rx_byte;
    push           = 1'b0;
    push_desc.bank = bank;
    push_desc.total = (raw_total > TOTAL_W'(BANK_SZ)) ? TOTAL_W'(BANK_SZ) : raw_total;
    if (accept) begin
      phase_next = PH_IDLE;  // any pattern break drops the byte
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte == HEADER_FIRST) begin
            wr.we      = 1'b1;
            wr.addr    = {bank, POS_W'(0)};
            phase_next = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (rx_byte == HEADER_SECOND) begin
            wr.we      = 1'b1;
            wr.addr    = {bank, POS_W'(1)};
            phase_next = PH_FUNC;
          end
        end
        PH_FUNC: begin
          if (rx_byte != 8'd0 && rx_byte < FUNC_LIMIT) begin
            wr.we      = 1'b1;
            wr.addr    = {bank, POS_W'(2)};
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte < 8'(LENGTH_LIMIT)) begin
            wr.we          = 1'b1;
            wr.addr        = {bank, POS_W'(3)};
            remaining_next = rx_byte[POS_W-1:0];
            count_next     = '0;
            phase_next     = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // zero remaining (zero length) falls through as a break
          if (remaining != '0) begin
            wr.we          = 1'b1;
            count_next     = count + POS_W'(1);
            remaining_next = remaining - POS_W'(1);
            phase_next     = (remaining == POS_W'(1)) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_TRAILER: begin
          wr.we     = 1'b1;
          push      = 1'b1;
          bank_next = ~bank;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      remaining <= '0;
      count     <= '0;
      bank      <= 1'b0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      count     <= count_next;
      bank      <= bank_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/dhlfr_queue.sv =====
// Two-entry descriptor queue between the parser and the drain.
// Depends on dhlfr_pkg.
`default_nettype none

module dhlfr_queue
  import dhlfr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  frame_desc_t push_desc,
  input  wire logic   pop,
  output frame_desc_t head,
  output logic        not_empty,
  output logic [1:0]  fill
);

  frame_desc_t slots [2];
  logic        wptr, rptr;

  assign head      = slots[rptr];
  assign not_empty = (fill != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/dhlfr_back.sv =====
// Back end: holds the two-bank frame store and drains a completed frame one
// beat per unstalled cycle; the store's read register is the output register.
// Depends on dhlfr_pkg.
`default_nettype none

module dhlfr_back
  import dhlfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  store_wr_t        wr,
  input  frame_desc_t      head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             draining,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic [POS_W-1:0] byte_index,
  output logic             last_of_frame
);

  logic [7:0] mem [STORE_DEPTH];

  logic               bank;
  logic [TOTAL_W-1:0] total;
  logic [POS_W-1:0]   k;
  logic               advance;
  logic               is_last;

  assign advance = !out_valid || !out_stall;
  assign pop     = !draining && head_valid;
  assign is_last = ({1'b0, k} + TOTAL_W'(1)) == total;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (advance && draining) begin
      frame_byte    <= mem[{bank, k}];
      byte_index    <= k;
      last_of_frame <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bank  <= head.bank;
      total <= head.total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (pop) begin
        draining <= 1'b1;
        k        <= '0;
      end else if (advance && draining) begin
        k <= k + POS_W'(1);
        if (is_last) draining <= 1'b0;
      end
      if (advance) out_valid <= draining;
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_header_length_frame_receiver.sv =====
// Top level of the dual-header length-prefixed frame receiver.
// Depends on dhlfr_pkg, dhlfr_front, dhlfr_queue and dhlfr_back.
//
//   channel | signals                                       | dir
//   --------+-----------------------------------------------+-----
//   input   | in_valid, in_stall, rx_byte                   | in
//   output  | out_valid, out_stall, frame_byte, byte_index, | out
//           | last_of_frame                                 |
//
// Each accepted input beat is parsed as it arrives. A finished frame of N
// bytes leaves as N output beats, one per unstalled cycle, via the queue and
// the drain. The store has two banks: input stalls only while two finished
// frames are waiting or draining. Synchronous reset clears the parser, queue
// and drain; the store needs no clearing. Output stalls hold the current beat.
`default_nettype none

module dual_header_length_frame_receiver
  import dhlfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic [5:0]       byte_index,
  output logic             last_of_frame
);

  store_wr_t   wr;
  frame_desc_t push_desc;
  frame_desc_t head;
  logic        push;
  logic        pop;
  logic        head_valid;
  logic [1:0]  fill;
  logic        draining;
  logic        accept;

  // both banks taken once two frames are queued or draining
  assign in_stall = ({1'b0, fill} + {2'b00, draining}) >= 3'd2;
  assign accept   = in_valid && !in_stall;

  dhlfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .wr        (wr),
    .push      (push),
    .push_desc (push_desc)
  );

  dhlfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .fill      (fill)
  );

  dhlfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .draining      (draining),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_index    (byte_index),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for dual_header_length_frame_receiver: byte-level frame parsing and replay.
// Predicts each emitted frame from the accepted input bytes and checks every output beat.
// Depends on dhlfr_pkg and the RTL under src/.
`default_nettype none

module tb;
  import dhlfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR2, PH_FUNC, PH_LEN, PH_PAYLOAD, PH_TRAILER
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } frame_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       last_of_frame;

  dual_header_length_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .frame_byte(frame_byte),
    .byte_index(byte_index), .last_of_frame(last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the parser
  parse_phase_t parse_ph = PH_IDLE;
  logic [5:0]   left_cnt = '0;
  logic [5:0]   got_cnt  = '0;
  logic [7:0]   frame_mem [64];

  frame_beat_t pending_beats [$];
  int          errors       = 0;
  int          quiet_cycles = 0;
  int          bytes_sent   = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          hold_seq     = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;

  task automatic parse_byte(input logic [7:0] b);
    int          total;
    frame_beat_t beat;
    case (parse_ph)
      PH_IDLE: begin
        if (b == HEADER_FIRST) begin
          frame_mem[0] = b;
          parse_ph = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b == HEADER_SECOND) begin
          frame_mem[1] = b;
          parse_ph = PH_FUNC;
        end else parse_ph = PH_IDLE;
      end
      PH_FUNC: begin
        if (b != 8'h00 && b < FUNC_LIMIT) begin
          frame_mem[2] = b;
          parse_ph = PH_LEN;
        end else parse_ph = PH_IDLE;
      end
      PH_LEN: begin
        if (int'(b) < int'(LENGTH_LIMIT)) begin
          frame_mem[3] = b;
          left_cnt = b[5:0];
          got_cnt = '0;
          parse_ph = PH_PAYLOAD;
        end else parse_ph = PH_IDLE;
      end
      PH_PAYLOAD: begin
        // zero length lands here with nothing left: byte is dropped
        if (left_cnt != '0) begin
          frame_mem[6'(got_cnt + 6'd4)] = b;
          got_cnt++;
          left_cnt--;
          if (left_cnt == '0) parse_ph = PH_TRAILER;
        end else parse_ph = PH_IDLE;
      end
      PH_TRAILER: begin
        frame_mem[6'(got_cnt + 6'd4)] = b;
        total = int'(got_cnt) + 5;
        for (int k = 0; k < total; k++) begin
          beat.data = frame_mem[k];
          beat.pos  = 6'(k);
          beat.last = (k == total - 1);
          pending_beats.push_back(beat);
        end
        parse_ph = PH_IDLE;
      end
      default: parse_ph = PH_IDLE;
    endcase
  endtask

  // input/output monitor, checker and watchdog
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (pending_beats.size() == 0) begin
          $error("output beat with none expected: frame_byte %h byte_index %0d",
                 frame_byte, byte_index);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          if (frame_byte !== want.data) begin
            $error("frame_byte: expected %h, got %h", want.data, frame_byte);
            errors++;
          end
          if (byte_index !== want.pos) begin
            $error("byte_index: expected %0d, got %0d", want.pos, byte_index);
            errors++;
          end
          if (last_of_frame !== want.last) begin
            $error("last_of_frame: expected %b, got %b", want.last, last_of_frame);
            errors++;
          end
        end
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(input int len);
    send_byte(HEADER_FIRST);
    send_byte(HEADER_SECOND);
    send_byte(8'($urandom_range(1, FUNC_LIMIT - 1)));
    send_byte(8'(len));
    repeat (len) send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  // sequences that fall back to idle part way through, or random bytes
  task automatic send_broken;
    logic [7:0] b;
    case ($urandom_range(5))
      0: begin
        b = 8'($urandom);
        if (b == HEADER_SECOND) b = 8'h00;
        send_bytes('{HEADER_FIRST, b});
      end
      1: send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h00});
      2: send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'($urandom_range(FUNC_LIMIT, 255))});
      3: send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'($urandom_range(1, 240)),
                      8'($urandom_range(LENGTH_LIMIT, 255))});
      4: send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'($urandom_range(1, 240)), 8'h00,
                      8'($urandom)});
      default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    endcase
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
  endtask

  task automatic test_directed_frames;
    // shortest frames, function byte at both ends, payload all zeros and all ones
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h01, 8'h01, 8'h00, 8'hFF});
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'hF0, 8'h01, 8'hFF, 8'h00});
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h55, 8'h02, 8'hAA, 8'hAF, 8'h3C});
  endtask

  task automatic test_pattern_breaks;
    // repeated first header is dropped, not taken as a new start
    send_bytes('{HEADER_FIRST, HEADER_FIRST});
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h00});
    send_bytes('{HEADER_FIRST, HEADER_SECOND, FUNC_LIMIT});
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h01, 8'(LENGTH_LIMIT)});
    // zero length: the next byte is swallowed even if it is a header
    send_bytes('{HEADER_FIRST, HEADER_SECOND, 8'h01, 8'h00, HEADER_FIRST});
    wait_drained();
  endtask

  task automatic test_output_holdoff;
    set_idling(0, 0);
    hold_seq <= hold_seq + 1;
    @(posedge clk);
    repeat (4) send_frame(8);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_bytes);
    int stop_at;
    set_idling(idle, stall);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) == 0) send_frame($urandom_range(9, LENGTH_LIMIT - 1));
        else send_frame($urandom_range(1, 8));
      end else begin
        send_broken();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_pattern_breaks();
    test_output_holdoff();

    set_idling(0, 0);
    send_frame(LENGTH_LIMIT - 1);  // longest frame, byte_index up to 53
    test_random_traffic(0, 0, 40);
    test_random_traffic(50, 0, 40);
    test_random_traffic(0, 50, 40);
    test_random_traffic(36, 36, 40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== dual_header_length_frame_receiver.f =====
src/dhlfr_pkg.sv
src/dhlfr_front.sv
src/dhlfr_queue.sv
src/dhlfr_back.sv
src/dual_header_length_frame_receiver.sv
test/tb.sv
